FILE: design/dra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dra_pkg
// shared codes, defaults and control types of the damage rectangle block
// ----------------------------------------------------------------------------
package dra_pkg;

  localparam int unsigned MaxRectsDefault  = 3;
  localparam int unsigned CoordBitsDefault = 16;
  localparam int unsigned InBits           = 15;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_WHOLE = 2'd1,
    OP_DRAIN = 2'd2
  } op_e;

  // control of one cell of the rectangle ring
  typedef struct packed {
    logic shift;
    logic ins;
  } cell_ctrl_t;

endpackage

FILE: design/dra_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dra_cell
// one stage of the rectangle ring: holds a rectangle and its area
// ----------------------------------------------------------------------------
module dra_cell #(
  parameter int unsigned W = dra_pkg::CoordBitsDefault
) (
  input  logic                  clk_i,
  input  dra_pkg::cell_ctrl_t   ctrl_i,
  input  logic signed [W-1:0]   nbr_l_i,
  input  logic signed [W-1:0]   nbr_t_i,
  input  logic signed [W-1:0]   nbr_r_i,
  input  logic signed [W-1:0]   nbr_b_i,
  input  logic        [2*W-1:0] nbr_area_i,
  input  logic signed [W-1:0]   ins_l_i,
  input  logic signed [W-1:0]   ins_t_i,
  input  logic signed [W-1:0]   ins_r_i,
  input  logic signed [W-1:0]   ins_b_i,
  input  logic        [2*W-1:0] ins_area_i,
  output logic signed [W-1:0]   l_o,
  output logic signed [W-1:0]   t_o,
  output logic signed [W-1:0]   r_o,
  output logic signed [W-1:0]   b_o,
  output logic        [2*W-1:0] area_o
);

  logic signed [W-1:0]   l_q, t_q, r_q, b_q;
  logic        [2*W-1:0] area_q;

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.shift) begin
      if (ctrl_i.ins) begin
        l_q    <= ins_l_i;
        t_q    <= ins_t_i;
        r_q    <= ins_r_i;
        b_q    <= ins_b_i;
        area_q <= ins_area_i;
      end else begin
        l_q    <= nbr_l_i;
        t_q    <= nbr_t_i;
        r_q    <= nbr_r_i;
        b_q    <= nbr_b_i;
        area_q <= nbr_area_i;
      end
    end
  end

  assign l_o    = l_q;
  assign t_o    = t_q;
  assign r_o    = r_q;
  assign b_o    = b_q;
  assign area_o = area_q;

endmodule

FILE: design/dra_eval.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dra_eval
// two-stage scoring of the ring head against the added rectangle
// ----------------------------------------------------------------------------
module dra_eval #(
  parameter int unsigned W  = dra_pkg::CoordBitsDefault,
  parameter int unsigned IW = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic        [IW-1:0]  pos_i,
  input  logic signed [W-1:0]   s_l_i,
  input  logic signed [W-1:0]   s_t_i,
  input  logic signed [W-1:0]   s_r_i,
  input  logic signed [W-1:0]   s_b_i,
  input  logic        [2*W-1:0] s_area_i,
  input  logic signed [W-1:0]   a_l_i,
  input  logic signed [W-1:0]   a_t_i,
  input  logic signed [W-1:0]   a_r_i,
  input  logic signed [W-1:0]   a_b_i,
  input  logic        [2*W-1:0] a_area_i,
  output logic                  valid_o,
  output logic        [IW-1:0]  pos_o,
  output logic                  touch_o,
  output logic                  ratio_ok_o,
  output logic        [2*W-1:0] cost_o,
  output logic        [2*W-1:0] area_m_o
);

  logic signed [W:0]   sl2, st2, sr2, sb2, al, at, ar, ab;
  logic signed [W-1:0] ml, mt, mr, mb;
  logic signed [W:0]   dw_full, dh_full;
  logic                touch;

  logic                v1_q, v2_q;
  logic [IW-1:0]       p1_q, p2_q;
  logic                t1_q, t2_q;
  logic [W-1:0]        dw_q, dh_q;
  logic [2*W-1:0]      sa1_q, sa2_q;
  logic [2*W:0]        sep1_q, sep2_q;
  logic [2*W-1:0]      am_q;
  logic [2*W+3:0]      lhs, rhs;

  always_comb begin
    sl2 = (W+1)'(s_l_i) - (W+1)'(2);
    st2 = (W+1)'(s_t_i) - (W+1)'(2);
    sr2 = (W+1)'(s_r_i) + (W+1)'(2);
    sb2 = (W+1)'(s_b_i) + (W+1)'(2);
    al  = (W+1)'(a_l_i);
    at  = (W+1)'(a_t_i);
    ar  = (W+1)'(a_r_i);
    ab  = (W+1)'(a_b_i);
    // overlap of the grown head with the added rectangle
    touch = (sl2 < ar) && (al < sr2) && (st2 < ab) && (at < sb2);
    ml = (s_l_i < a_l_i) ? s_l_i : a_l_i;
    mt = (s_t_i < a_t_i) ? s_t_i : a_t_i;
    mr = (s_r_i > a_r_i) ? s_r_i : a_r_i;
    mb = (s_b_i > a_b_i) ? s_b_i : a_b_i;
    dw_full = (W+1)'(mr) - (W+1)'(ml);
    dh_full = (W+1)'(mb) - (W+1)'(mt);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q   <= pos_i;
    t1_q   <= touch;
    dw_q   <= dw_full[W-1:0];
    dh_q   <= dh_full[W-1:0];
    sa1_q  <= s_area_i;
    sep1_q <= {1'b0, s_area_i} + {1'b0, a_area_i};
    p2_q   <= p1_q;
    t2_q   <= t1_q;
    sa2_q  <= sa1_q;
    sep2_q <= sep1_q;
    am_q   <= dw_q * dh_q;
  end

  // joined area * 4 against separate sum * 5
  assign lhs = {2'b00, am_q, 2'b00};
  assign rhs = {1'b0, sep2_q, 2'b00} + {3'b000, sep2_q};

  assign valid_o    = v2_q;
  assign pos_o      = p2_q;
  assign touch_o    = t2_q;
  assign ratio_ok_o = (lhs <= rhs);
  assign cost_o     = am_q - sa2_q;
  assign area_m_o   = am_q;

endmodule

FILE: design/dirty_rectangle_accumulator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dirty_rectangle_accumulator
// gathers screen damage into a few merged rectangles and a whole-screen flag
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid_i / in_stall_o) carries an op and a rectangle:
//   add, mark whole screen or drain at frame start. output channel
//   (out_valid_o / out_stall_i) carries one damage rectangle per transfer,
//   or one whole-screen result, with last_o on the final one of a drain.
//   the stored rectangles sit in a ring of MAX_RECTS cells that rotates one
//   step a cycle during a walk, and during a drain while the receiver takes
//   results, past a two-stage scoring unit. an add that is kept stalls the
//   input after its transfer through the area, scoring walk and write-back
//   walk states. ignored adds and mark whole do not stall the input. a drain
//   emits one result a cycle while the receiver takes them; out_valid_o
//   rises once the drain state is reached and the output register is free.
//   reset sets the whole-screen flag and empties the store, so the first
//   drain reports the whole screen.
//   when the receiver stalls the result register holds; the block keeps
//   taking adds while a result waits, a further drain waits for room
// ----------------------------------------------------------------------------
module dirty_rectangle_accumulator #(
  parameter int unsigned MAX_RECTS  = dra_pkg::MaxRectsDefault,
  parameter int unsigned COORD_BITS = dra_pkg::CoordBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         op_i,
  input  logic signed [dra_pkg::InBits-1:0]  rect_left_i,
  input  logic signed [dra_pkg::InBits-1:0]  rect_top_i,
  input  logic signed [dra_pkg::InBits-1:0]  rect_right_i,
  input  logic signed [dra_pkg::InBits-1:0]  rect_bottom_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               whole_screen_o,
  output logic signed [COORD_BITS-1:0]       out_left_o,
  output logic signed [COORD_BITS-1:0]       out_top_o,
  output logic signed [COORD_BITS-1:0]       out_right_o,
  output logic signed [COORD_BITS-1:0]       out_bottom_o,
  output logic                               last_o
);

  localparam int unsigned W  = COORD_BITS;
  localparam int unsigned N  = MAX_RECTS;
  localparam int unsigned IW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);
  localparam int unsigned SW = $clog2(N + 3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_WALK,
    ST_APPLY,
    ST_DRAIN
  } state_e;

  state_e state_q;
  logic [CW-1:0] count_q;
  logic          whole_q;
  logic [SW-1:0] step_q;

  // added rectangle, already grown by the margin
  logic signed [W-1:0] a_l_q, a_t_q, a_r_q, a_b_q;
  logic [2*W-1:0]      area_a_q;

  // walk results
  logic           touch_hit_q, ratio_hit_q, best_hit_q;
  logic [IW-1:0]  touch_idx_q, ratio_idx_q, best_idx_q;
  logic [2*W-1:0] touch_area_q, ratio_area_q, best_area_q, best_cost_q;

  // output register
  logic                out_valid_q, whole_out_q, last_q;
  logic signed [W-1:0] ol_q, ot_q, or_q, ob_q;

  // ring of cells
  logic signed [W-1:0] cl [N];
  logic signed [W-1:0] ct [N];
  logic signed [W-1:0] cr [N];
  logic signed [W-1:0] cb [N];
  logic [2*W-1:0]      ca [N];

  logic                ring_shift, ring_ins;
  logic signed [W-1:0] ins_l, ins_t, ins_r, ins_b;
  logic [2*W-1:0]      ins_area;

  dra_pkg::cell_ctrl_t ctrl_mid, ctrl_tail;

  assign ctrl_mid.shift  = ring_shift;
  assign ctrl_mid.ins    = 1'b0;
  assign ctrl_tail.shift = ring_shift;
  assign ctrl_tail.ins   = ring_ins;

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == N - 1) begin : g_tail
      dra_cell #(.W(W)) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl_tail),
        .nbr_l_i    (cl[0]),
        .nbr_t_i    (ct[0]),
        .nbr_r_i    (cr[0]),
        .nbr_b_i    (cb[0]),
        .nbr_area_i (ca[0]),
        .ins_l_i    (ins_l),
        .ins_t_i    (ins_t),
        .ins_r_i    (ins_r),
        .ins_b_i    (ins_b),
        .ins_area_i (ins_area),
        .l_o        (cl[g]),
        .t_o        (ct[g]),
        .r_o        (cr[g]),
        .b_o        (cb[g]),
        .area_o     (ca[g])
      );
    end else begin : g_body
      dra_cell #(.W(W)) u_cell (
        .clk_i      (clk_i),
        .ctrl_i     (ctrl_mid),
        .nbr_l_i    (cl[g+1]),
        .nbr_t_i    (ct[g+1]),
        .nbr_r_i    (cr[g+1]),
        .nbr_b_i    (cb[g+1]),
        .nbr_area_i (ca[g+1]),
        .ins_l_i    (ins_l),
        .ins_t_i    (ins_t),
        .ins_r_i    (ins_r),
        .ins_b_i    (ins_b),
        .ins_area_i (ins_area),
        .l_o        (cl[g]),
        .t_o        (ct[g]),
        .r_o        (cr[g]),
        .b_o        (cb[g]),
        .area_o     (ca[g])
      );
    end
  end

  // scoring unit at the ring head
  logic           ev_valid_in;
  logic           ev_valid, ev_touch, ev_ratio;
  logic [IW-1:0]  ev_pos;
  logic [2*W-1:0] ev_cost, ev_area_m;

  assign ev_valid_in = (state_q == ST_WALK) && (step_q < SW'(N)) &&
                       (step_q < SW'(count_q));

  dra_eval #(.W(W), .IW(IW)) u_eval (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (ev_valid_in),
    .pos_i      (step_q[IW-1:0]),
    .s_l_i      (cl[0]),
    .s_t_i      (ct[0]),
    .s_r_i      (cr[0]),
    .s_b_i      (cb[0]),
    .s_area_i   (ca[0]),
    .a_l_i      (a_l_q),
    .a_t_i      (a_t_q),
    .a_r_i      (a_r_q),
    .a_b_i      (a_b_q),
    .a_area_i   (area_a_q),
    .valid_o    (ev_valid),
    .pos_o      (ev_pos),
    .touch_o    (ev_touch),
    .ratio_ok_o (ev_ratio),
    .cost_o     (ev_cost),
    .area_m_o   (ev_area_m)
  );

  // write-back choice: touch, then ratio, then free slot, then least growth
  logic           do_fill;
  logic [IW-1:0]  tgt_idx;
  logic [2*W-1:0] tgt_area;

  always_comb begin
    do_fill  = 1'b0;
    tgt_idx  = best_idx_q;
    tgt_area = best_area_q;
    if (touch_hit_q) begin
      tgt_idx  = touch_idx_q;
      tgt_area = touch_area_q;
    end else if (ratio_hit_q) begin
      tgt_idx  = ratio_idx_q;
      tgt_area = ratio_area_q;
    end else if (count_q < CW'(N)) begin
      do_fill  = 1'b1;
      tgt_idx  = count_q[IW-1:0];
      tgt_area = area_a_q;
    end
  end

  always_comb begin
    if (do_fill) begin
      ins_l = a_l_q;
      ins_t = a_t_q;
      ins_r = a_r_q;
      ins_b = a_b_q;
    end else begin
      ins_l = (cl[0] < a_l_q) ? cl[0] : a_l_q;
      ins_t = (ct[0] < a_t_q) ? ct[0] : a_t_q;
      ins_r = (cr[0] > a_r_q) ? cr[0] : a_r_q;
      ins_b = (cb[0] > a_b_q) ? cb[0] : a_b_q;
    end
    ins_area = tgt_area;
  end

  logic out_free, drain_emit;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign drain_emit = (state_q == ST_DRAIN) && out_free;

  assign ring_ins   = (state_q == ST_APPLY) && (step_q[IW-1:0] == tgt_idx);
  assign ring_shift = ((state_q == ST_WALK) && (step_q < SW'(N))) ||
                      (state_q == ST_APPLY) ||
                      (drain_emit && !whole_q && (count_q != '0));

  assign in_stall_o = (state_q != ST_IDLE);

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  logic signed [W-1:0] gl, gt, gr, gb;
  logic [W-1:0]        aw, ah;
  always_comb begin
    gl = W'(rect_left_i) - W'(2);
    gt = W'(rect_top_i) - W'(2);
    gr = W'(rect_right_i) + W'(2);
    gb = W'(rect_bottom_i) + W'(2);
    aw = a_r_q - a_l_q;
    ah = a_b_q - a_t_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      whole_q     <= 1'b1;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      touch_hit_q <= 1'b0;
      ratio_hit_q <= 1'b0;
      best_hit_q  <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_xfer) begin
            unique case (op_i)
              dra_pkg::OP_ADD: begin
                // empty rectangles and adds under the flag are dropped
                if (!whole_q && (rect_left_i < rect_right_i) &&
                    (rect_top_i < rect_bottom_i)) begin
                  state_q <= ST_AREA;
                end
              end
              dra_pkg::OP_WHOLE: begin
                whole_q <= 1'b1;
                count_q <= '0;
              end
              dra_pkg::OP_DRAIN: begin
                state_q <= ST_DRAIN;
              end
              default: begin
              end
            endcase
          end
        end
        ST_AREA: begin
          step_q      <= '0;
          touch_hit_q <= 1'b0;
          ratio_hit_q <= 1'b0;
          best_hit_q  <= 1'b0;
          state_q     <= ST_WALK;
        end
        ST_WALK: begin
          if (ev_valid) begin
            if (!touch_hit_q && ev_touch) begin
              touch_hit_q  <= 1'b1;
              touch_idx_q  <= ev_pos;
              touch_area_q <= ev_area_m;
            end
            if (!ratio_hit_q && ev_ratio) begin
              ratio_hit_q  <= 1'b1;
              ratio_idx_q  <= ev_pos;
              ratio_area_q <= ev_area_m;
            end
            // strict compare keeps the first slot on ties
            if (!best_hit_q || (ev_cost < best_cost_q)) begin
              best_hit_q  <= 1'b1;
              best_idx_q  <= ev_pos;
              best_area_q <= ev_area_m;
              best_cost_q <= ev_cost;
            end
          end
          if (step_q == SW'(N + 1)) begin
            step_q  <= '0;
            state_q <= ST_APPLY;
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        ST_APPLY: begin
          if (step_q == SW'(N - 1)) begin
            step_q  <= '0;
            state_q <= ST_IDLE;
            if (do_fill) begin
              count_q <= count_q + CW'(1);
            end
          end else begin
            step_q <= step_q + SW'(1);
          end
        end
        ST_DRAIN: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            if (whole_q || (count_q == '0)) begin
              whole_out_q <= 1'b1;
              ol_q        <= '0;
              ot_q        <= '0;
              or_q        <= '0;
              ob_q        <= '0;
              last_q      <= 1'b1;
              whole_q     <= 1'b0;
              count_q     <= '0;
              state_q     <= ST_IDLE;
            end else begin
              whole_out_q <= 1'b0;
              ol_q        <= cl[0];
              ot_q        <= ct[0];
              or_q        <= cr[0];
              ob_q        <= cb[0];
              last_q      <= (count_q == CW'(1));
              count_q     <= count_q - CW'(1);
              if (count_q == CW'(1)) begin
                state_q <= ST_IDLE;
              end
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // operand capture and area of the added rectangle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      a_l_q <= gl;
      a_t_q <= gt;
      a_r_q <= gr;
      a_b_q <= gb;
    end
    if (state_q == ST_AREA) begin
      area_a_q <= aw * ah;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign whole_screen_o = whole_out_q;
  assign out_left_o     = ol_q;
  assign out_top_o      = ot_q;
  assign out_right_o    = or_q;
  assign out_bottom_o   = ob_q;
  assign last_o         = last_q;

  // the store is never over-full
  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(N))
    else $error("rectangle count beyond capacity");

  // under the whole-screen flag nothing is stored
  a_whole_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    whole_q |-> (count_q == '0))
    else $error("rectangles kept under whole-screen flag");

  // a whole-screen result always closes its drain
  a_whole_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && whole_screen_o) |-> last_o)
    else $error("whole-screen result without last");

  // a drain transfer always starts a result sequence
  a_drain_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && (op_i == dra_pkg::OP_DRAIN)) |=> in_stall_o)
    else $error("drain did not occupy the block");

endmodule
